/* design/assert_macros.svh */
// Assertion macros shared by the variable admittance force loop RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/vafl_pkg.sv */
// Types, constants and helper functions of the variable admittance force loop.
// Depends on nothing; used by every module of the block.
package vafl_pkg;

    typedef struct packed {
        logic signed [31:0] measured_force;
        logic signed [31:0] measured_velocity;
        logic signed [31:0] measured_position;
        logic [15:0]        elapsed_time;
    } t_in_word;

    typedef struct packed {
        logic signed [20:0] command_velocity;
        logic signed [31:0] command_position;
        logic signed [31:0] integral_term;
    } t_out_word;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] wdata;
    } t_cfg_word;

    typedef enum logic [2:0] {
        CFG_DESIRED_FORCE = 3'd0,
        CFG_DAMPING       = 3'd1,
        CFG_ACCEL_GAIN    = 3'd2,
        CFG_VEL_LIMIT     = 3'd3,
        CFG_VEL_DEADBAND  = 3'd4,
        CFG_SIGMA_OFFSET  = 3'd5
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_ERR, S_DEN, S_MDEN, S_DIV0, S_DIVW, S_PHI, S_SUMV, S_MSUM,
        S_INNER, S_MLO, S_MHI, S_ACC, S_MADT, S_VEL, S_MVDT, S_POS
    } t_state;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 45;
    localparam int DIV_Q_W   = 17;

    localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = $signed(x[31:0]);
        end
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        logic [31:0] r;
        r = x[31] ? (~x + 32'd1) : x;
        return r;
    endfunction

endpackage

/* design/vafl_chan_if.sv */
// Valid/ready channel that carries one word of a packed payload type.
// Depends on nothing; the payload type comes from the instantiating level.
interface vafl_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/vafl_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on vafl_pkg for the operand widths.
module vafl_mul import vafl_pkg::*; (
    input  logic                        i_clk,
    input  logic signed [MUL_A_W-1:0]   i_a,
    input  logic signed [MUL_B_W-1:0]   i_b,
    output logic signed [MUL_P_W-1:0]   o_p
);
    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

/* design/vafl_div.sv */
// Restoring divider that yields one quotient bit per cycle.
// Depends on vafl_pkg for the operand and quotient widths.
module vafl_div import vafl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIV_NUM_W-1:0]  i_num,
    input  logic [DIV_DEN_W-1:0]  i_den,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [DIV_Q_W-1:0]    o_quot
);
    localparam int DSH_W = DIV_DEN_W + DIV_Q_W - 1;
    localparam int CNT_W = $clog2(DIV_Q_W);

    logic [DIV_NUM_W-1:0] r_rem;
    logic [DSH_W-1:0]     r_dsh;
    logic [DIV_Q_W-1:0]   r_quot;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic                 r_zero;
    logic                 fits;

    assign fits = {{(DSH_W-DIV_NUM_W){1'b0}}, r_rem} >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= {i_den, {(DIV_Q_W-1){1'b0}}};
            r_quot <= '0;
            r_cnt  <= CNT_W'(DIV_Q_W - 1);
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dsh[DIV_NUM_W-1:0];
            end
            r_quot <= {r_quot[DIV_Q_W-2:0], fits};
            r_dsh  <= r_dsh >> 1;
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_quot;
endmodule

/* design/variable_admittance_force_loop_core.sv */
// One item is accepted in the idle state; its result is written to the output register
// in S_POS, and the next item is accepted only after the block returns to idle.
// The pace is set by the 17-step divider and the one shared multiplier.
// A finished word waits in the output register while the next item is taken;
// a second finished word stalls the block until that register is read.
// Synchronous reset restores register reset values and clears phi and previous error.
`include "assert_macros.svh"
module variable_admittance_force_loop_core import vafl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vafl_chan_if.sink   i_in_ch,
    vafl_chan_if.source o_out_ch,
    vafl_chan_if.sink   i_cfg_ch
);
    t_state r_state, n_state;

    logic signed [31:0] r_desired;
    logic [11:0]        r_damping;
    logic [15:0]        r_gain;
    logic [19:0]        r_vlim;
    logic [15:0]        r_vdb;
    logic [30:0]        r_soff;

    logic signed [31:0] r_phi, r_prev;

    logic signed [31:0] r_f, r_vel, r_pos;
    logic [15:0]        r_dt;
    logic signed [31:0] r_e;
    logic [32:0]        r_den;
    logic signed [32:0] r_sum;
    logic signed [46:0] r_inner;
    logic [39:0]        r_plo;
    logic signed [31:0] r_accel;
    logic signed [20:0] r_v;
    t_out_word          r_out;
    logic               r_out_valid;

    logic                      in_ready, in_acc, out_free;
    logic [11:0]               b_eff;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic                      div_start, div_busy, div_done;
    logic [DIV_Q_W-1:0]        div_quot;

    logic signed [32:0] diff;
    logic signed [33:0] delta, phi_diff;
    logic signed [63:0] acc_hi, acc_lo, acc_sum, acc_sh;
    logic signed [31:0] adt;
    logic signed [32:0] v_sum;
    logic [32:0]        v_mag;
    logic signed [32:0] lim;
    logic signed [20:0] vdt;
    logic signed [32:0] cpos;

    assign in_acc   = i_in_ch.valid && in_ready;
    assign out_free = !r_out_valid || o_out_ch.ready;
    assign b_eff    = (r_damping == '0) ? 12'd1 : r_damping;

    assign i_in_ch.ready  = in_ready;
    assign i_cfg_ch.ready = 1'b1;
    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.data  = r_out;

    vafl_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    vafl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({mag32(r_prev), 16'b0}),
        .i_den   (prod[DIV_DEN_W-1:0]),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = S_ERR;
            S_ERR:   n_state = S_DEN;
            S_DEN:   n_state = S_MDEN;
            S_MDEN:  n_state = S_DIV0;
            S_DIV0:  n_state = S_DIVW;
            S_DIVW:  if (div_done) n_state = S_PHI;
            S_PHI:   n_state = S_SUMV;
            S_SUMV:  n_state = S_MSUM;
            S_MSUM:  n_state = S_INNER;
            S_INNER: n_state = S_MLO;
            S_MLO:   n_state = S_MHI;
            S_MHI:   n_state = S_ACC;
            S_ACC:   n_state = S_MADT;
            S_MADT:  n_state = S_VEL;
            S_VEL:   n_state = S_MVDT;
            S_MVDT:  n_state = S_POS;
            S_POS:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (r_state)
            S_IDLE: in_ready = 1'b1;
            S_MDEN: begin
                mul_a = {1'b0, r_den};
                mul_b = {6'b0, b_eff};
            end
            S_DIV0: div_start = 1'b1;
            S_MSUM: begin
                mul_a = {r_sum[32], r_sum};
                mul_b = {6'b0, b_eff};
            end
            S_MLO: begin
                mul_a = {10'b0, r_inner[23:0]};
                mul_b = {2'b0, r_gain};
            end
            S_MHI: begin
                mul_a = {{11{r_inner[46]}}, r_inner[46:24]};
                mul_b = {2'b0, r_gain};
            end
            S_MADT: begin
                mul_a = {{2{r_accel[31]}}, r_accel};
                mul_b = {2'b0, r_dt};
            end
            S_MVDT, S_POS: begin
                mul_a = {{13{r_v[20]}}, r_v};
                mul_b = {2'b0, r_dt};
            end
            default: begin
            end
        endcase
    end

    assign diff     = {r_f[31], r_f} - {r_desired[31], r_desired};
    assign delta    = r_prev[31] ? -{17'b0, div_quot} : {17'b0, div_quot};
    assign phi_diff = {{2{r_phi[31]}}, r_phi} - delta;
    assign acc_hi   = {prod[39:0], 24'b0};
    assign acc_lo   = {24'b0, r_plo};
    assign acc_sum  = acc_hi + acc_lo;
    assign acc_sh   = acc_sum >>> 8;
    assign adt      = prod[47:16];
    assign v_sum    = {r_vel[31], r_vel} + {adt[31], adt};
    assign v_mag    = v_sum[32] ? (~v_sum + 33'd1) : v_sum;
    assign lim      = {13'b0, r_vlim};
    assign vdt      = prod[36:16];
    assign cpos     = {r_pos[31], r_pos} + {{12{vdt[20]}}, vdt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_desired   <= 32'sd655360;
            r_damping   <= 12'd250;
            r_gain      <= 16'd1280;
            r_vlim      <= 20'd65536;
            r_vdb       <= 16'd7;
            r_soff      <= 31'd655360;
            r_phi       <= '0;
            r_prev      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_ch.valid) begin
                case (i_cfg_ch.data.index)
                    CFG_DESIRED_FORCE: r_desired <= $signed(i_cfg_ch.data.wdata);
                    CFG_DAMPING:       r_damping <= i_cfg_ch.data.wdata[11:0];
                    CFG_ACCEL_GAIN:    r_gain    <= i_cfg_ch.data.wdata[15:0];
                    CFG_VEL_LIMIT:     r_vlim    <= i_cfg_ch.data.wdata[19:0];
                    CFG_VEL_DEADBAND:  r_vdb     <= i_cfg_ch.data.wdata[15:0];
                    CFG_SIGMA_OFFSET:  r_soff    <= i_cfg_ch.data.wdata[30:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == S_PHI) begin
                r_phi <= sat32({{30{phi_diff[33]}}, phi_diff});
            end
            if (r_state == S_POS && out_free) begin
                r_prev      <= r_e;
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_f   <= i_in_ch.data.measured_force;
            r_vel <= i_in_ch.data.measured_velocity;
            r_pos <= i_in_ch.data.measured_position;
            r_dt  <= i_in_ch.data.elapsed_time;
        end
        unique case (r_state)
            S_ERR:   r_e <= sat32({{31{diff[32]}}, diff});
            S_DEN:   r_den <= {1'b0, mag32(r_e)} + {1'b0, mag32(r_prev)} + {2'b0, r_soff};
            S_SUMV:  r_sum <= {r_vel[31], r_vel} + {r_phi[31], r_phi};
            S_INNER: r_inner <= {{15{r_e[31]}}, r_e} - {prod[45], prod[45:0]};
            S_MHI:   r_plo <= prod[39:0];
            S_ACC:   r_accel <= sat32(acc_sh);
            S_VEL: begin
                if (v_mag < {17'b0, r_vdb}) begin
                    r_v <= '0;
                end else if (v_sum > lim) begin
                    r_v <= {1'b0, r_vlim};
                end else if (v_sum < -lim) begin
                    r_v <= -{1'b0, r_vlim};
                end else begin
                    r_v <= v_sum[20:0];
                end
            end
            S_POS: begin
                if (out_free) begin
                    r_out.command_velocity <= r_v;
                    r_out.command_position <= sat32({{31{cpos[32]}}, cpos});
                    r_out.integral_term    <= r_phi;
                end
            end
            default: begin
            end
        endcase
    end

    `ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_state == S_ERR)
    `ASSERT_IMP(a_word_from_pos, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_POS)
    `ASSERT_NXT(a_div_to_phi, i_clk, i_rst_n, r_state == S_DIVW && div_done, r_state == S_PHI)
    `ASSERT_IMP(a_div_idle, i_clk, i_rst_n, r_state != S_DIVW, !div_busy && !div_done)
endmodule
